FILE: rtl/circle_fan_tessellator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circle fan tessellator
// Shared concurrent assertion forms, clocked on clk and reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_FAN_TESSELLATOR_MACROS_SVH
`define CIRCLE_FAN_TESSELLATOR_MACROS_SVH

// Same-cycle implication
`define CFT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circle fan tessellator: same-cycle check failed");

// Next-cycle implication
`define CFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circle fan tessellator: next-cycle check failed");

`endif

FILE: rtl/cft_pkg.sv
// ----------------------------------------------------------------------------
// Circle fan tessellator package
// Constants, request and status types, sequencer states and CORDIC table.
// ----------------------------------------------------------------------------
`default_nettype none

package cft_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int CORDIC_ITERS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_STEPS = (CORDIC_ITERS < ATAN_ENTRIES) ? CORDIC_ITERS : ATAN_ENTRIES;
    localparam int MIN_SEGMENTS = 3;
    localparam int DIV_STEPS    = 61;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [32:0]        AXIS_THRESH = 33'd58982;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // One classified request, as handed from front to back
    typedef struct packed {
        logic [2:0][31:0] center;
        logic [2:0][31:0] normal;
        logic [2:0][32:0] raw;
        logic [30:0]      radius;
        logic [6:0]       nseg;
        logic [31:0]      color;
        logic             fill;
    } cft_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cft_qstat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NABS,
        ST_NSHIFT,
        ST_NSQ,
        ST_SQRT,
        ST_DIVSET,
        ST_DIV,
        ST_CROSS,
        ST_PDIV,
        ST_PLACE,
        ST_ANGLE,
        ST_CSET,
        ST_CORDIC,
        ST_DOT,
        ST_EMIT
    } cft_state_t;

    // Arctangent of 2^-k in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] a;
        case (k)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41721;
            5'd15:   a = 32'd20860;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2607;
            5'd19:   a = 32'd1303;
            5'd20:   a = 32'd651;
            5'd21:   a = 32'd325;
            5'd22:   a = 32'd162;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/circle_fan_tessellator.sv
// Setup: basis setup per request (two normalizations, each a shift search,
//   a 32-step square root and three 61-step divisions, then a 61-step phase-step division),
//   then per segment 16 CORDIC steps and nine products on one shared multiplier.
// Requests: the back end works on one request at a time; a request with
//   fewer than three segments is dropped in the front end at once.
// Reset: rst_n is asynchronous, active low; clears the queue, sequencer and basis state.
// ----------------------------------------------------------------------------
// Circle fan tessellator
// Front end and request queue feed a sequenced back end that walks the rim.
// ----------------------------------------------------------------------------
`default_nettype none
`include "circle_fan_tessellator_macros.svh"

module circle_fan_tessellator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] center_x,
    input  wire logic signed [31:0] center_y,
    input  wire logic signed [31:0] center_z,
    input  wire logic signed [31:0] normal_x,
    input  wire logic signed [31:0] normal_y,
    input  wire logic signed [31:0] normal_z,
    input  wire logic [30:0]        radius,
    input  wire logic [6:0]         segments,
    input  wire logic [31:0]        color,
    input  wire logic               fill,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      start_x,
    output logic signed [31:0]      start_y,
    output logic signed [31:0]      start_z,
    output logic signed [31:0]      end_x,
    output logic signed [31:0]      end_y,
    output logic signed [31:0]      end_z,
    output logic signed [31:0]      hub_x,
    output logic signed [31:0]      hub_y,
    output logic signed [31:0]      hub_z,
    output logic [31:0]             rgba,
    output logic                    kind,
    output logic                    last
);
    import cft_pkg::*;

    logic       q_push;
    logic       q_pop;
    cft_req_t   q_wdata;
    cft_req_t   q_rdata;
    cft_qstat_t q_stat;

    // Accept and classify requests
    cft_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .center_x (center_x),
        .center_y (center_y),
        .center_z (center_z),
        .normal_x (normal_x),
        .normal_y (normal_y),
        .normal_z (normal_z),
        .radius   (radius),
        .segments (segments),
        .color    (color),
        .fill     (fill),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_stat   (q_stat)
    );

    // Decouple front and back
    cft_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_pop   (q_pop),
        .q_rdata (q_rdata),
        .q_stat  (q_stat)
    );

    // Walk the rim and deliver segments
    cft_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rdata),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .start_x (start_x),
        .start_y (start_y),
        .start_z (start_z),
        .end_x   (end_x),
        .end_y   (end_y),
        .end_z   (end_z),
        .hub_x   (hub_x),
        .hub_y   (hub_y),
        .hub_z   (hub_z),
        .rgba    (rgba),
        .kind    (kind),
        .last    (last)
    );

    // Check that outline hubs are zero, the queue is never overrun or underrun, and a push fills an empty queue
    `CFT_ASSERT_IMPL(a_line_hub_zero, !empty && !kind, hub_x == 32'sd0 && hub_y == 32'sd0 && hub_z == 32'sd0)
    `CFT_ASSERT_IMPL(a_push_not_full, q_push, !q_stat.full)
    `CFT_ASSERT_IMPL(a_pop_not_empty, q_pop, !q_stat.empty)
    `CFT_ASSERT_NEXT(a_push_fills, q_push && !q_pop && q_stat.empty, !q_stat.empty)

endmodule

`default_nettype wire

FILE: rtl/cft_front.sv
// ----------------------------------------------------------------------------
// Circle fan tessellator front end
// Accept requests, drop short ones, clamp the count and pick the helper axis.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] center_x,
    input  wire logic signed [31:0] center_y,
    input  wire logic signed [31:0] center_z,
    input  wire logic signed [31:0] normal_x,
    input  wire logic signed [31:0] normal_y,
    input  wire logic signed [31:0] normal_z,
    input  wire logic [30:0]        radius,
    input  wire logic [6:0]         segments,
    input  wire logic [31:0]        color,
    input  wire logic               fill,
    output logic                    q_push,
    output cft_pkg::cft_req_t       q_data,
    input  wire cft_pkg::cft_qstat_t q_stat
);
    import cft_pkg::*;

    logic     stage_valid_reg, stage_valid_next;
    cft_req_t stage_reg, stage_next;
    logic     accept;
    logic     keep;
    logic [32:0] ny_ext, ny_abs, nx_ext, nz_ext;

    assign full   = stage_valid_reg && q_stat.full;
    assign accept = push && !full;
    assign q_push = stage_valid_reg && !q_stat.full;
    assign q_data = stage_reg;
    assign keep   = segments >= 7'(MIN_SEGMENTS);

    // Classify the incoming request
    always_comb
    begin
        nx_ext = {normal_x[31], normal_x};
        ny_ext = {normal_y[31], normal_y};
        nz_ext = {normal_z[31], normal_z};
        ny_abs = normal_y[31] ? (33'd0 - ny_ext) : ny_ext;

        stage_next.center = {center_z, center_y, center_x};
        stage_next.normal = {normal_z, normal_y, normal_x};
        if (ny_abs > AXIS_THRESH)
        begin
            stage_next.raw = {33'd0 - ny_ext, nz_ext, 33'd0};
        end
        else
        begin
            stage_next.raw = {nx_ext, 33'd0, 33'd0 - nz_ext};
        end
        stage_next.radius = radius;
        stage_next.nseg   = (segments > 7'(MAX_SEGMENTS)) ? 7'(MAX_SEGMENTS) : segments;
        stage_next.color  = color;
        stage_next.fill   = fill;

        stage_valid_next = stage_valid_reg;
        if (q_push)
        begin
            stage_valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            stage_valid_next = 1'b1;
        end
    end

    // Hold the classified request until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cft_queue.sv
// ----------------------------------------------------------------------------
// Circle fan tessellator request queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_push,
    input  wire cft_pkg::cft_req_t   q_wdata,
    input  wire logic                q_pop,
    output cft_pkg::cft_req_t        q_rdata,
    output cft_pkg::cft_qstat_t      q_stat
);
    import cft_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cft_req_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;
    assign do_push      = q_push && !q_stat.full;
    assign do_pop       = q_pop && !q_stat.empty;
    assign q_rdata      = mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_wdata;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cft_back.sv
// ----------------------------------------------------------------------------
// Circle fan tessellator back end
// Sequencer: basis normalization, phase step, CORDIC and rim placement.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cft_pkg::cft_req_t   q_data,
    input  wire cft_pkg::cft_qstat_t q_stat,
    output logic                     q_pop,
    output logic                     empty,
    input  wire logic                pop,
    output logic signed [31:0]       start_x,
    output logic signed [31:0]       start_y,
    output logic signed [31:0]       start_z,
    output logic signed [31:0]       end_x,
    output logic signed [31:0]       end_y,
    output logic signed [31:0]       end_z,
    output logic signed [31:0]       hub_x,
    output logic signed [31:0]       hub_y,
    output logic signed [31:0]       hub_z,
    output logic [31:0]              rgba,
    output logic                     kind,
    output logic                     last
);
    import cft_pkg::*;

    // Round half up at bit 30
    function automatic logic signed [37:0] rnd30(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = (p + 68'sd536870912) >>> 30;
        return t[37:0];
    endfunction

    function automatic logic [1:0] nxt1(input logic [1:0] j);
        return (j == 2'd2) ? 2'd0 : j + 2'd1;
    endfunction

    function automatic logic [1:0] nxt2(input logic [1:0] j);
        return (j == 2'd0) ? 2'd2 : j - 2'd1;
    endfunction

    cft_state_t state_reg, state_next;
    cft_req_t   req_reg, req_next;

    logic signed [63:0] vec_reg [3];
    logic signed [63:0] vec_next [3];
    logic [62:0]        mag_reg [3];
    logic [62:0]        mag_next [3];
    logic [63:0]        sum_reg, sum_next;
    logic [63:0]        sq_x_reg, sq_x_next;
    logic [63:0]        sq_res_reg, sq_res_next;
    logic [63:0]        sq_bit_reg, sq_bit_next;
    logic [31:0]        len_reg, len_next;
    logic [60:0]        div_num_reg, div_num_next;
    logic [31:0]        div_den_reg, div_den_next;
    logic [31:0]        div_rem_reg, div_rem_next;
    logic [31:0]        div_quo_reg, div_quo_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;
    logic [2:0]         idx_reg, idx_next;
    logic               ph_reg, ph_next;
    logic               vsel_reg, vsel_next;
    logic               first_reg, first_next;
    logic signed [31:0] u_reg [3];
    logic signed [31:0] u_next [3];
    logic signed [31:0] v_reg [3];
    logic signed [31:0] v_next [3];
    logic [31:0]        stepq_reg, stepq_next;
    logic [6:0]         stepr_reg, stepr_next;
    logic [32:0]        accq_reg, accq_next;
    logic [6:0]         accr_reg, accr_next;
    logic [6:0]         seg_reg, seg_next;
    logic signed [33:0] cord_x_reg, cord_x_next;
    logic signed [33:0] cord_y_reg, cord_y_next;
    logic signed [33:0] cord_z_reg, cord_z_next;
    logic [4:0]         cord_k_reg, cord_k_next;
    logic [1:0]         quad_reg, quad_next;
    logic signed [33:0] cs_reg, cs_next;
    logic signed [33:0] sn_reg, sn_next;
    logic signed [33:0] d_reg [3];
    logic signed [33:0] d_next [3];
    logic signed [67:0] acc_reg, acc_next;
    logic signed [67:0] prod_reg;
    logic signed [31:0] end_reg [3];
    logic signed [31:0] end_next [3];
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] prev_next [3];

    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic signed [31:0] o_start_reg [3];
    logic signed [31:0] o_end_reg [3];
    logic signed [31:0] o_hub_reg [3];
    logic [31:0]        o_rgba_reg;
    logic               o_kind_reg;
    logic               o_last_reg;

    logic signed [33:0] mul_a, mul_b;

    // Select the operands of the shared multiplier
    always_comb
    begin
        logic [1:0] j;
        logic [1:0] ai;
        logic [1:0] bi;
        j  = idx_reg[2:1];
        ai = idx_reg[0] ? nxt2(j) : nxt1(j);
        bi = idx_reg[0] ? nxt1(j) : nxt2(j);
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_NSQ:
            begin
                mul_a = {4'd0, mag_reg[idx_reg[1:0]][29:0]};
                mul_b = {4'd0, mag_reg[idx_reg[1:0]][29:0]};
            end
            ST_CROSS:
            begin
                mul_a = {{2{req_reg.normal[ai][31]}}, req_reg.normal[ai]};
                mul_b = {{2{u_reg[bi][31]}}, u_reg[bi]};
            end
            ST_DOT:
            begin
                mul_a = idx_reg[0] ? {{2{v_reg[j][31]}}, v_reg[j]} : {{2{u_reg[j][31]}}, u_reg[j]};
                mul_b = idx_reg[0] ? sn_reg : cs_reg;
            end
            ST_PLACE:
            begin
                mul_a = d_reg[idx_reg[1:0]];
                mul_b = {3'd0, req_reg.radius};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequence one request
    always_comb
    begin
        logic [63:0]        sq_t;
        logic [31:0]        dr;
        logic [31:0]        qv;
        logic signed [31:0] sv;
        logic [32:0]        aq;
        logic [7:0]         ar;
        logic [31:0]        phase;
        logic [31:0]        qsum;
        logic [31:0]        zw;
        logic signed [33:0] dx, dy, at;
        logic signed [37:0] off, cs38;
        logic signed [67:0] dsum;
        logic signed [37:0] dsr;
        logic [1:0]         j;

        state_next     = state_reg;
        req_next       = req_reg;
        sum_next       = sum_reg;
        sq_x_next      = sq_x_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        len_next       = len_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_cnt_next   = div_cnt_reg;
        idx_next       = idx_reg;
        ph_next        = ph_reg;
        vsel_next      = vsel_reg;
        first_next     = first_reg;
        stepq_next     = stepq_reg;
        stepr_next     = stepr_reg;
        accq_next      = accq_reg;
        accr_next      = accr_reg;
        seg_next       = seg_reg;
        cord_x_next    = cord_x_reg;
        cord_y_next    = cord_y_reg;
        cord_z_next    = cord_z_reg;
        cord_k_next    = cord_k_reg;
        quad_next      = quad_reg;
        cs_next        = cs_reg;
        sn_next        = sn_reg;
        acc_next       = acc_reg;
        vec_next       = vec_reg;
        mag_next       = mag_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        d_next         = d_reg;
        end_next       = end_reg;
        prev_next      = prev_reg;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !pop;

        j    = idx_reg[1:0];
        sq_t = sq_res_reg + sq_bit_reg;
        dr   = {div_rem_reg[30:0], div_num_reg[60]};
        qv   = (len_reg == '0) ? '0 : div_quo_reg;
        sv   = vec_reg[j][63] ? (32'sd0 - $signed(qv)) : $signed(qv);
        aq   = accq_reg + {1'b0, stepq_reg};
        ar   = {1'b0, accr_reg} + {1'b0, stepr_reg};
        phase = accq_reg[31:0];
        qsum = phase + 32'h2000_0000;
        zw   = phase - {qsum[31:30], 30'd0};
        dx   = cord_y_reg >>> cord_k_reg;
        dy   = cord_x_reg >>> cord_k_reg;
        at   = $signed({2'b00, atan_turn(cord_k_reg)});
        off  = rnd30(prod_reg);
        cs38 = {{6{req_reg.center[j][31]}}, req_reg.center[j]} + off;
        dsum = acc_reg + prod_reg;
        dsr  = rnd30(dsum);

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop    = 1'b1;
                    req_next = q_data;
                    for (int k = 0; k < 3; k++)
                    begin
                        vec_next[k] = {{31{q_data.raw[k][32]}}, q_data.raw[k]};
                    end
                    vsel_next  = 1'b0;
                    state_next = ST_NABS;
                end
            end
            ST_NABS:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mag_next[k] = vec_reg[k][63] ? 63'(64'sd0 - vec_reg[k]) : vec_reg[k][62:0];
                end
                state_next = ST_NSHIFT;
            end
            ST_NSHIFT:
            begin
                // Shift until every magnitude is below 2^30
                if ((|mag_reg[0][62:30]) || (|mag_reg[1][62:30]) || (|mag_reg[2][62:30]))
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_next[k] = mag_reg[k] >> 1;
                    end
                end
                else
                begin
                    idx_next   = '0;
                    ph_next    = 1'b0;
                    sum_next   = '0;
                    state_next = ST_NSQ;
                end
            end
            ST_NSQ:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next  = 1'b0;
                    sum_next = sum_reg + prod_reg[63:0];
                    if (idx_reg == 3'd2)
                    begin
                        sq_x_next   = sum_reg + prod_reg[63:0];
                        sq_res_next = '0;
                        sq_bit_next = 64'h4000_0000_0000_0000;
                        state_next  = ST_SQRT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            ST_SQRT:
            begin
                // Two result bits per step pair, one step a cycle
                if (sq_bit_reg != '0)
                begin
                    if (sq_x_reg >= sq_t)
                    begin
                        sq_x_next   = sq_x_reg - sq_t;
                        sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_res_next = sq_res_reg >> 1;
                    end
                    sq_bit_next = sq_bit_reg >> 2;
                end
                else
                begin
                    len_next   = sq_res_reg[31:0];
                    idx_next   = '0;
                    state_next = ST_DIVSET;
                end
            end
            ST_DIVSET:
            begin
                div_num_next = {1'b0, mag_reg[j][29:0], 30'd0} + {30'd0, len_reg[31:1]};
                div_den_next = len_reg;
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = 6'(DIV_STEPS);
                state_next   = ST_DIV;
            end
            ST_DIV, ST_PDIV:
            begin
                if (div_cnt_reg != '0)
                begin
                    if (dr >= div_den_reg)
                    begin
                        div_rem_next = dr - div_den_reg;
                        div_quo_next = {div_quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        div_rem_next = dr;
                        div_quo_next = {div_quo_reg[30:0], 1'b0};
                    end
                    div_num_next = {div_num_reg[59:0], 1'b0};
                    div_cnt_next = div_cnt_reg - 6'd1;
                end
                else if (state_reg == ST_PDIV)
                begin
                    // Phase step found: start the rim walk at u
                    stepq_next = div_quo_reg;
                    stepr_next = div_rem_reg[6:0];
                    accq_next  = '0;
                    accr_next  = '0;
                    seg_next   = '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        d_next[k] = {{2{u_reg[k][31]}}, u_reg[k]};
                    end
                    first_next = 1'b1;
                    idx_next   = '0;
                    ph_next    = 1'b0;
                    state_next = ST_PLACE;
                end
                else
                begin
                    if (vsel_reg)
                    begin
                        v_next[j] = sv;
                    end
                    else
                    begin
                        u_next[j] = sv;
                    end
                    if (idx_reg == 3'd2)
                    begin
                        idx_next = '0;
                        ph_next  = 1'b0;
                        if (!vsel_reg)
                        begin
                            state_next = ST_CROSS;
                        end
                        else
                        begin
                            div_num_next = {28'd0, 1'b1, 32'd0};
                            div_den_next = {25'd0, req_reg.nseg};
                            div_rem_next = '0;
                            div_quo_next = '0;
                            div_cnt_next = 6'(DIV_STEPS);
                            state_next   = ST_PDIV;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_DIVSET;
                    end
                end
            end
            ST_CROSS:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    if (!idx_reg[0])
                    begin
                        vec_next[idx_reg[2:1]] = prod_reg[63:0];
                    end
                    else
                    begin
                        vec_next[idx_reg[2:1]] = vec_reg[idx_reg[2:1]] - prod_reg[63:0];
                    end
                    if (idx_reg == 3'd5)
                    begin
                        vsel_next  = 1'b1;
                        state_next = ST_NABS;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            ST_PLACE:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    // Saturate center plus offset
                    if (cs38 > 38'sd2147483647)
                    begin
                        end_next[j] = 32'sh7FFF_FFFF;
                    end
                    else if (cs38 < -38'sd2147483648)
                    begin
                        end_next[j] = 32'sh8000_0000;
                    end
                    else
                    begin
                        end_next[j] = cs38[31:0];
                    end
                    if (idx_reg == 3'd2)
                    begin
                        state_next = first_reg ? ST_ANGLE : ST_EMIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            ST_ANGLE:
            begin
                if (first_reg)
                begin
                    prev_next  = end_reg;
                    first_next = 1'b0;
                end
                if (ar >= {1'b0, req_reg.nseg})
                begin
                    accq_next = aq + 33'd1;
                    accr_next = 7'(ar - {1'b0, req_reg.nseg});
                end
                else
                begin
                    accq_next = aq;
                    accr_next = ar[6:0];
                end
                seg_next   = seg_reg + 7'd1;
                state_next = ST_CSET;
            end
            ST_CSET:
            begin
                quad_next   = qsum[31:30];
                cord_z_next = {{2{zw[31]}}, zw};
                cord_x_next = CORDIC_GAIN;
                cord_y_next = '0;
                cord_k_next = '0;
                state_next  = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (cord_k_reg < 5'(CORDIC_STEPS))
                begin
                    if (!cord_z_reg[33])
                    begin
                        cord_x_next = cord_x_reg - dx;
                        cord_y_next = cord_y_reg + dy;
                        cord_z_next = cord_z_reg - at;
                    end
                    else
                    begin
                        cord_x_next = cord_x_reg + dx;
                        cord_y_next = cord_y_reg - dy;
                        cord_z_next = cord_z_reg + at;
                    end
                    cord_k_next = cord_k_reg + 5'd1;
                end
                else
                begin
                    // Rotate back into the quadrant
                    case (quad_reg)
                        2'd1:
                        begin
                            cs_next = -cord_y_reg;
                            sn_next = cord_x_reg;
                        end
                        2'd2:
                        begin
                            cs_next = -cord_x_reg;
                            sn_next = -cord_y_reg;
                        end
                        2'd3:
                        begin
                            cs_next = cord_y_reg;
                            sn_next = -cord_x_reg;
                        end
                        default:
                        begin
                            cs_next = cord_x_reg;
                            sn_next = cord_y_reg;
                        end
                    endcase
                    idx_next   = '0;
                    ph_next    = 1'b0;
                    state_next = ST_DOT;
                end
            end
            ST_DOT:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    if (!idx_reg[0])
                    begin
                        acc_next = prod_reg;
                    end
                    else
                    begin
                        d_next[idx_reg[2:1]] = dsr[33:0];
                    end
                    if (idx_reg == 3'd5)
                    begin
                        idx_next   = '0;
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    prev_next      = end_reg;
                    state_next     = (seg_reg == req_reg.nseg) ? ST_IDLE : ST_ANGLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            ph_reg        <= 1'b0;
            vsel_reg      <= 1'b0;
            first_reg     <= 1'b0;
            seg_reg       <= '0;
            div_cnt_reg   <= '0;
            cord_k_reg    <= '0;
            for (int k = 0; k < 3; k++)
            begin
                u_reg[k]    <= '0;
                v_reg[k]    <= '0;
                prev_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            ph_reg        <= ph_next;
            vsel_reg      <= vsel_next;
            first_reg     <= first_next;
            seg_reg       <= seg_next;
            div_cnt_reg   <= div_cnt_next;
            cord_k_reg    <= cord_k_next;
            u_reg         <= u_next;
            v_reg         <= v_next;
            prev_reg      <= prev_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        vec_reg     <= vec_next;
        mag_reg     <= mag_next;
        sum_reg     <= sum_next;
        sq_x_reg    <= sq_x_next;
        sq_res_reg  <= sq_res_next;
        sq_bit_reg  <= sq_bit_next;
        len_reg     <= len_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        stepq_reg   <= stepq_next;
        stepr_reg   <= stepr_next;
        accq_reg    <= accq_next;
        accr_reg    <= accr_next;
        cord_x_reg  <= cord_x_next;
        cord_y_reg  <= cord_y_next;
        cord_z_reg  <= cord_z_next;
        quad_reg    <= quad_next;
        cs_reg      <= cs_next;
        sn_reg      <= sn_next;
        acc_reg     <= acc_next;
        d_reg       <= d_next;
        end_reg     <= end_next;
        prod_reg    <= mul_a * mul_b;
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                o_start_reg[k] <= prev_reg[k];
                o_end_reg[k]   <= end_reg[k];
                o_hub_reg[k]   <= req_reg.fill ? $signed(req_reg.center[k]) : 32'sd0;
            end
            o_rgba_reg <= req_reg.color;
            o_kind_reg <= req_reg.fill;
            o_last_reg <= seg_reg == req_reg.nseg;
        end
    end

    assign empty   = !out_valid_reg;
    assign start_x = o_start_reg[0];
    assign start_y = o_start_reg[1];
    assign start_z = o_start_reg[2];
    assign end_x   = o_end_reg[0];
    assign end_y   = o_end_reg[1];
    assign end_z   = o_end_reg[2];
    assign hub_x   = o_hub_reg[0];
    assign hub_y   = o_hub_reg[1];
    assign hub_z   = o_hub_reg[2];
    assign rgba    = o_rgba_reg;
    assign kind    = o_kind_reg;
    assign last    = o_last_reg;

endmodule

`default_nettype wire
